>>> rtl/core/lck_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lck_pkg: shared types and constants of the Legendre Christoffel kernel
// Fixed-point widths, sequencer states and divider request/response structs.
// ----------------------------------------------------------------------------
package lck_pkg;

    // term count range
    localparam int MAX_TERMS = 64;
    localparam int K_W       = $clog2(MAX_TERMS);          // recurrence index k
    localparam int N_W       = $clog2(MAX_TERMS + 1);      // term count n

    // port fields
    localparam int CFG_W     = 7;
    localparam int POINT_W   = 18;
    localparam int KERN_W    = 29;
    localparam int DENS_W    = 22;

    // datapath widths
    localparam int P_W       = 32;                         // Pk, Q2.30
    localparam int XP_W      = 33;                         // round(x*Pk), signed
    localparam int SQ_W      = 33;                         // round(Pk^2), unsigned Q.30
    localparam int MUL_W     = 34;                         // shared multiplier operand
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = SQ_W + 2 * K_W;             // weighted sum of squares
    localparam int NUM_W     = P_W + $clog2(3 * MAX_TERMS) + 1;
    localparam int DIV_STEP  = 4;                          // quotient bits per cycle
    localparam int DIV_W     = ((NUM_W - 1 + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_ITER  = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    // constants
    localparam logic signed [POINT_W-1:0] POINT_MAX = POINT_W'(65536);
    localparam logic signed [POINT_W-1:0] POINT_MIN = -POINT_W'(65536);
    localparam logic signed [P_W-1:0]     ONE_Q30   = P_W'(64'd1 << 30);
    localparam logic signed [P_W-1:0]     PK_MAX    = {1'b0, {(P_W-1){1'b1}}};
    localparam logic signed [P_W-1:0]     PK_MIN    = {1'b1, {(P_W-1){1'b0}}};
    localparam logic [CFG_W-1:0]          TERMS_RST = CFG_W'(2);

    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQR,
        S_WT,
        S_ACC,
        S_XP,
        S_XPR,
        S_M1,
        S_M2,
        S_NUM,
        S_DIVGO,
        S_DIV,
        S_FIN,
        S_DEN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [N_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/core/lck_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lck_div: iterative unsigned divider
// Restoring division of a wide dividend by a narrow divisor, several
// quotient bits per cycle; done pulses for a single cycle as the last step is registered.
// ----------------------------------------------------------------------------
module lck_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lck_pkg::t_div_req i_req,
    output lck_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [lck_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [lck_pkg::DIV_W-1:0]        r_quo;
    logic [lck_pkg::DIV_W-1:0]        n_quo;
    logic [lck_pkg::N_W-1:0]          r_rem;
    logic [lck_pkg::N_W-1:0]          n_rem;
    logic [lck_pkg::N_W-1:0]          r_den;
    logic [lck_pkg::N_W:0]            wide;

    // DIV_STEP restoring steps; remainder stays below the divisor
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        wide  = '0;
        for (int i = 0; i < lck_pkg::DIV_STEP; i++) begin
            wide  = {n_rem, n_quo[lck_pkg::DIV_W-1]};
            n_quo = {n_quo[lck_pkg::DIV_W-2:0], 1'b0};
            if (wide >= {1'b0, r_den}) begin
                n_rem    = lck_pkg::N_W'(wide - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = wide[lck_pkg::N_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= lck_pkg::DIV_CNT_W'(lck_pkg::DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - lck_pkg::DIV_CNT_W'(1);
                if (r_cnt == lck_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with empty step count");

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done)
        else $error("divider finished without done");

endmodule

>>> rtl/core/legendre_christoffel_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_christoffel_kernel: Christoffel kernel of Legendre polynomials
// Runs the three-term Legendre recurrence at one point and returns the
// kernel sum of (2k+1)*Pk(x)^2 and the density kernel/(2n).
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_term_count (n)
//  in       | in        | i_in_valid  / o_in_ready   | i_point (Q2.16)
//  out      | out       | o_out_valid / i_out_ready  | o_kernel_value, o_density_value
//
//  Sequence: one item at a time. Each recurrence step forms the numerator on
//  the shared multiplier (S_XP, S_XPR, S_M1, S_M2, S_NUM, S_DIVGO), divides
//  it in the divider (4 quotient bits a cycle, then done) and squares and
//  weights the new term (S_SQ, S_SQR, S_WT, S_ACC). The result waits for
//  i_out_ready; o_in_ready returns in the cycle after the result is taken.
//  Reset: synchronous, active low; term count returns to 2, sequencer idles.
//  Stalls: o_in_ready is high only while idle; the result holds in the
//  output registers until taken. Config writes are always taken.
//
// Datapath notes:
//  - one signed 34x34 multiplier, product registered, shared by the squares,
//    the weights, x*Pk, (2k+1)*xp and k*P(k-1)
//  - one iterative divider for the /(k+1) of each step and the final /n
//  - rounding is to nearest with ties away from zero; division rounding is
//    folded in by adding half the divisor to the magnitude first
// ----------------------------------------------------------------------------
module legendre_christoffel_kernel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lck_pkg::CFG_W-1:0]         i_cfg_term_count,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [lck_pkg::POINT_W-1:0] i_point,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lck_pkg::KERN_W-1:0]        o_kernel_value,
    output logic [lck_pkg::DENS_W-1:0]        o_density_value
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    lck_pkg::t_state                     r_state, n_state;
    logic [lck_pkg::CFG_W-1:0]           r_term_count;
    logic [lck_pkg::N_W-1:0]             r_terms, n_terms;     // effective n
    logic [lck_pkg::K_W-1:0]             r_k, n_k;             // index of P current
    logic signed [lck_pkg::P_W-1:0]      r_x30, n_x30;
    logic signed [lck_pkg::P_W-1:0]      r_p_prev, n_p_prev;
    logic signed [lck_pkg::P_W-1:0]      r_p_cur, n_p_cur;
    logic [lck_pkg::SUM_W-1:0]           r_sum, n_sum;
    logic [lck_pkg::SQ_W-1:0]            r_sq, n_sq;
    logic signed [lck_pkg::XP_W-1:0]     r_xp, n_xp;
    logic signed [lck_pkg::NUM_W-1:0]    r_t1, n_t1;
    logic signed [lck_pkg::NUM_W-1:0]    r_num, n_num;
    logic                                r_neg, n_neg;
    lck_pkg::t_prod                      r_prod, n_prod;
    logic [lck_pkg::KERN_W-1:0]          r_kern, n_kern;
    logic [lck_pkg::DENS_W-1:0]          r_dens, n_dens;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [lck_pkg::N_W-1:0]             eff_terms;
    logic signed [lck_pkg::POINT_W-1:0]  x_sat;
    logic signed [lck_pkg::P_W-1:0]      x30_in;
    logic [lck_pkg::K_W:0]               weight;      // 2k+1
    logic [lck_pkg::N_W-1:0]             k_plus1;
    logic [lck_pkg::N_W-1:0]             half;
    lck_pkg::t_mul                       mul_a, mul_b;
    logic [lck_pkg::PROD_W-1:0]          prod_mag;
    logic [lck_pkg::PROD_W-1:0]          xp_rnd;
    logic [lck_pkg::XP_W-1:0]            xp_mag;
    logic [lck_pkg::PROD_W-1:0]          sq_rnd;
    logic [lck_pkg::NUM_W-1:0]           num_u;
    logic [lck_pkg::NUM_W-1:0]           mag_rnd;
    logic [lck_pkg::SUM_W:0]             kern_rnd;
    logic [lck_pkg::SUM_W:0]             dens_num;
    logic [lck_pkg::DIV_W-1:0]           quo;
    logic signed [lck_pkg::P_W-1:0]      p_next;
    lck_pkg::t_div_req                   div_req;
    lck_pkg::t_div_rsp                   div_rsp;

    // term count: zero acts as one, large values clamp to the maximum
    always_comb begin
        if (r_term_count == '0) begin
            eff_terms = lck_pkg::N_W'(1);
        end else if (32'(r_term_count) > lck_pkg::MAX_TERMS) begin
            eff_terms = lck_pkg::N_W'(lck_pkg::MAX_TERMS);
        end else begin
            eff_terms = lck_pkg::N_W'(r_term_count);
        end
    end

    // point clamp to [-1, 1], then Q2.16 -> Q2.30
    always_comb begin
        if (i_point > lck_pkg::POINT_MAX) begin
            x_sat = lck_pkg::POINT_MAX;
        end else if (i_point < lck_pkg::POINT_MIN) begin
            x_sat = lck_pkg::POINT_MIN;
        end else begin
            x_sat = i_point;
        end
    end
    assign x30_in = lck_pkg::P_W'(x_sat) <<< 14;

    assign weight  = {r_k, 1'b1};
    assign k_plus1 = lck_pkg::N_W'(r_k) + lck_pkg::N_W'(1);
    assign half    = k_plus1 >> 1;

    // round(x*Pk / 2^30), ties away from zero
    assign prod_mag = r_prod[lck_pkg::PROD_W-1] ? lck_pkg::PROD_W'(-r_prod)
                                                : lck_pkg::PROD_W'(r_prod);
    assign xp_rnd   = prod_mag + lck_pkg::PROD_W'(64'd1 << 29);
    assign xp_mag   = xp_rnd[30 +: lck_pkg::XP_W];

    // round(Pk^2 / 2^30), product is never negative
    assign sq_rnd   = lck_pkg::PROD_W'(r_prod) + lck_pkg::PROD_W'(64'd1 << 29);

    // |num| + (k+1)/2 ahead of the divider
    assign num_u    = r_num;
    assign mag_rnd  = r_num[lck_pkg::NUM_W-1]
                    ? (~num_u + lck_pkg::NUM_W'(half) + lck_pkg::NUM_W'(1))
                    : (num_u + lck_pkg::NUM_W'(half));

    // final scaling
    assign kern_rnd = {1'b0, r_sum} + (lck_pkg::SUM_W+1)'(64'd1 << 13);
    assign dens_num = {1'b0, r_sum} + ((lck_pkg::SUM_W+1)'(r_terms) << 14);

    // signed quotient back to Q2.30 with saturation
    assign quo = div_rsp.quotient;
    always_comb begin
        if (!r_neg) begin
            if (quo > lck_pkg::DIV_W'(lck_pkg::PK_MAX)) begin
                p_next = lck_pkg::PK_MAX;
            end else begin
                p_next = lck_pkg::P_W'(quo);
            end
        end else begin
            if (quo >= (lck_pkg::DIV_W'(1) << (lck_pkg::P_W - 1))) begin
                p_next = lck_pkg::PK_MIN;
            end else begin
                p_next = lck_pkg::P_W'(~quo + lck_pkg::DIV_W'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state, multiplier operands, divider requests
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_terms  = r_terms;
        n_k      = r_k;
        n_x30    = r_x30;
        n_p_prev = r_p_prev;
        n_p_cur  = r_p_cur;
        n_sum    = r_sum;
        n_sq     = r_sq;
        n_xp     = r_xp;
        n_t1     = r_t1;
        n_num    = r_num;
        n_neg    = r_neg;
        n_kern   = r_kern;
        n_dens   = r_dens;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;

        case (r_state)
            lck_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_terms  = eff_terms;
                    n_x30    = x30_in;
                    n_p_prev = lck_pkg::ONE_Q30;
                    n_p_cur  = x30_in;
                    // square of P0 is exactly 1.0
                    n_sum    = lck_pkg::SUM_W'(lck_pkg::ONE_Q30);
                    n_k      = lck_pkg::K_W'(1);
                    n_state  = (eff_terms >= lck_pkg::N_W'(2)) ? lck_pkg::S_SQ
                                                                : lck_pkg::S_FIN;
                end
            end
            lck_pkg::S_SQ: begin
                mul_a   = lck_pkg::t_mul'(r_p_cur);
                mul_b   = lck_pkg::t_mul'(r_p_cur);
                n_state = lck_pkg::S_SQR;
            end
            lck_pkg::S_SQR: begin
                n_sq    = sq_rnd[30 +: lck_pkg::SQ_W];
                n_state = lck_pkg::S_WT;
            end
            lck_pkg::S_WT: begin
                mul_a   = lck_pkg::t_mul'(weight);
                mul_b   = lck_pkg::t_mul'(r_sq);
                n_state = lck_pkg::S_ACC;
            end
            lck_pkg::S_ACC: begin
                n_sum   = r_sum + r_prod[lck_pkg::SUM_W-1:0];
                n_state = (k_plus1 < r_terms) ? lck_pkg::S_XP : lck_pkg::S_FIN;
            end
            lck_pkg::S_XP: begin
                mul_a   = lck_pkg::t_mul'(r_x30);
                mul_b   = lck_pkg::t_mul'(r_p_cur);
                n_state = lck_pkg::S_XPR;
            end
            lck_pkg::S_XPR: begin
                n_xp    = r_prod[lck_pkg::PROD_W-1] ? -$signed(xp_mag) : $signed(xp_mag);
                n_state = lck_pkg::S_M1;
            end
            lck_pkg::S_M1: begin
                mul_a   = lck_pkg::t_mul'(weight);
                mul_b   = lck_pkg::t_mul'(r_xp);
                n_state = lck_pkg::S_M2;
            end
            lck_pkg::S_M2: begin
                n_t1    = lck_pkg::NUM_W'(r_prod);
                mul_a   = lck_pkg::t_mul'(r_k);
                mul_b   = lck_pkg::t_mul'(r_p_prev);
                n_state = lck_pkg::S_NUM;
            end
            lck_pkg::S_NUM: begin
                n_num   = r_t1 - lck_pkg::NUM_W'(r_prod);
                n_state = lck_pkg::S_DIVGO;
            end
            lck_pkg::S_DIVGO: begin
                div_req.start    = 1'b1;
                div_req.dividend = lck_pkg::DIV_W'(mag_rnd);
                div_req.divisor  = k_plus1;
                n_neg            = r_num[lck_pkg::NUM_W-1];
                n_state          = lck_pkg::S_DIV;
            end
            lck_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_p_prev = r_p_cur;
                    n_p_cur  = p_next;
                    n_k      = r_k + lck_pkg::K_W'(1);
                    n_state  = lck_pkg::S_SQ;
                end
            end
            lck_pkg::S_FIN: begin
                if (|kern_rnd[lck_pkg::SUM_W:14+lck_pkg::KERN_W]) begin
                    n_kern = '1;
                end else begin
                    n_kern = kern_rnd[14 +: lck_pkg::KERN_W];
                end
                div_req.start    = 1'b1;
                div_req.dividend = lck_pkg::DIV_W'(dens_num[lck_pkg::SUM_W:15]);
                div_req.divisor  = r_terms;
                n_state          = lck_pkg::S_DEN;
            end
            lck_pkg::S_DEN: begin
                if (div_rsp.done) begin
                    if (|quo[lck_pkg::DIV_W-1:lck_pkg::DENS_W]) begin
                        n_dens = '1;
                    end else begin
                        n_dens = quo[lck_pkg::DENS_W-1:0];
                    end
                    n_state = lck_pkg::S_OUT;
                end
            end
            lck_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = lck_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lck_pkg::S_IDLE;
            end
        endcase
    end

    // shared multiplier, product registered
    assign n_prod = mul_a * mul_b;

    // ------------------------------------------------------------------
    // state and config registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lck_pkg::S_IDLE;
            r_term_count <= lck_pkg::TERMS_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term_count <= i_cfg_term_count;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_terms  <= n_terms;
        r_k      <= n_k;
        r_x30    <= n_x30;
        r_p_prev <= n_p_prev;
        r_p_cur  <= n_p_cur;
        r_sum    <= n_sum;
        r_sq     <= n_sq;
        r_xp     <= n_xp;
        r_t1     <= n_t1;
        r_num    <= n_num;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_kern   <= n_kern;
        r_dens   <= n_dens;
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    lck_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == lck_pkg::S_IDLE);
    assign o_out_valid     = (r_state == lck_pkg::S_OUT);
    assign o_kernel_value  = r_kern;
    assign o_density_value = r_dens;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready did not drop after accept");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lck_pkg::S_XP) |-> (k_plus1 < r_terms))
        else $error("recurrence step beyond term count");

    a_dens_le_kern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ({{(lck_pkg::KERN_W-lck_pkg::DENS_W){1'b0}}, o_density_value}
             <= o_kernel_value))
        else $error("density above kernel");

endmodule
